// ----- src/sgr_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse gap-run decoder package
// Shared field widths, command and result codes, and the request, result and
// internal operation types.
// ----------------------------------------------------------------------------
`default_nettype none

package sgr_pkg;

	localparam int FIELD_W = 62;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_GAP   = 2'd1,
		CMD_EOS   = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		KIND_ROW      = 2'd0,
		KIND_DONE     = 2'd1,
		KIND_IDLE_GAP = 2'd2
	} kind_e;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [FIELD_W-1:0] gap_count;
		logic               granule_end;
		logic [FIELD_W-1:0] start_row;
		logic [FIELD_W-1:0] skip_rows;
		logic [FIELD_W-1:0] row_limit;
		logic               keep_carry;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [FIELD_W-1:0] row_index;
		logic [FIELD_W-1:0] rows_read;
		logic [FIELD_W-1:0] skipped_values;
	} out_item_t;

	typedef struct packed {
		cmd_e               cmd;
		logic [FIELD_W-1:0] gap_count;
		logic               granule_end;
		logic [FIELD_W-1:0] start_row;
		logic [FIELD_W-1:0] skip_rows;
		logic [FIELD_W-1:0] row_limit;
		logic [FIELD_W-1:0] win_end;
		logic               keep_carry;
	} op_t;

endpackage

`default_nettype wire

// ----- src/sgr_fifo.sv -----
// ----------------------------------------------------------------------------
// Sparse gap-run decoder queue
// Small register queue with count-based full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire T     din,
	output logic      full,
	input  wire logic pop,
	output T          dout,
	output logic      empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

`default_nettype wire

// ----- src/sgr_front.sv -----
// ----------------------------------------------------------------------------
// Sparse gap-run decoder front end
// Accepts requests, drops unused command codes, masks fields to the row width
// and precomputes the saturated window end.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_front
	import sgr_pkg::*;
#(
	parameter int ROW_BITS = 62
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire in_item_t item,
	output logic          full,
	output logic          op_valid,
	output op_t           op,
	input  wire logic     op_full
);

	localparam int W = ROW_BITS;

	logic            valid_s1;
	op_t             op_s1;
	logic            known;
	logic [W-1:0]    off;
	logic [W-1:0]    lim;
	logic [W:0]      end_sum;
	logic [W-1:0]    win_end;
	op_t             op_next;

	assign full     = valid_s1 && op_full;
	assign op_valid = valid_s1 && !op_full;
	assign op       = op_s1;

	always_comb begin
		known   = (item.cmd == CMD_BEGIN) || (item.cmd == CMD_GAP) || (item.cmd == CMD_EOS);
		off     = item.skip_rows[W-1:0];
		lim     = item.row_limit[W-1:0];
		end_sum = {1'b0, off} + {1'b0, lim};
		win_end = end_sum[W] ? '1 : end_sum[W-1:0];

		op_next.cmd         = cmd_e'(item.cmd);
		op_next.gap_count   = FIELD_W'(item.gap_count[W-1:0]);
		op_next.granule_end = item.granule_end;
		op_next.start_row   = FIELD_W'(item.start_row[W-1:0]);
		op_next.skip_rows   = FIELD_W'(off);
		op_next.row_limit   = FIELD_W'(lim);
		op_next.win_end     = FIELD_W'(win_end);
		op_next.keep_carry  = item.keep_carry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push && known;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			op_s1 <= op_next;
		end
	end

endmodule

`default_nettype wire

// ----- src/sgr_back.sv -----
// ----------------------------------------------------------------------------
// Sparse gap-run decoder back end
// Holds the read window and carried state, and turns each operation into at
// most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_back
	import sgr_pkg::*;
#(
	parameter int ROW_BITS = 62
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic op_valid,
	input  wire op_t  op,
	output logic      op_pop,
	input  wire logic res_full,
	output logic      res_push,
	output out_item_t res
);

	localparam int W = ROW_BITS;

	function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[W] ? '1 : s[W-1:0];
	endfunction

	logic [W-1:0] td_q, rows_seen_q, skip_left_q, last_row_q, skip_cnt_q;
	logic [W-1:0] base_q, skip_q, limit_q, win_end_q;
	logic         vp_q, active_q, none_q;

	logic [W-1:0] n_td, n_rows_seen, n_skip_left, n_last_row, n_skip_cnt;
	logic [W-1:0] n_base, n_skip, n_limit, n_win_end;
	logic         n_vp, n_active, n_none;

	logic [W-1:0] gap, start, off, lim, we;
	logic [W-1:0] td_eff, nxt, grp, base, row, rows;
	logic         vp_eff, has_res;
	kind_e        kind;

	assign op_pop   = op_valid && !res_full;
	assign res_push = op_pop && has_res;

	always_comb begin
		gap    = op.gap_count[W-1:0];
		start  = op.start_row[W-1:0];
		off    = op.skip_rows[W-1:0];
		lim    = op.row_limit[W-1:0];
		we     = op.win_end[W-1:0];
		td_eff = (op.cmd == CMD_BEGIN && !op.keep_carry) ? '0 : td_q;
		vp_eff = (op.cmd == CMD_BEGIN && !op.keep_carry) ? 1'b0 : vp_q;
		nxt    = sat_add(rows_seen_q, gap);
		grp    = sat_add(gap, td_q);
		base   = none_q ? base_q : sat_add(last_row_q, W'(1));

		n_td        = td_q;
		n_vp        = vp_q;
		n_active    = active_q;
		n_rows_seen = rows_seen_q;
		n_skip_left = skip_left_q;
		n_none      = none_q;
		n_last_row  = last_row_q;
		n_skip_cnt  = skip_cnt_q;
		n_base      = base_q;
		n_skip      = skip_q;
		n_limit     = limit_q;
		n_win_end   = win_end_q;

		has_res = 1'b0;
		kind    = KIND_ROW;
		row     = '0;
		rows    = '0;
		res.skipped_values = '0;

		unique case (op.cmd)
			CMD_BEGIN: begin
				n_base     = start;
				n_skip     = off;
				n_limit    = lim;
				n_win_end  = we;
				n_skip_cnt = '0;
				n_td       = td_eff;
				n_vp       = vp_eff;
				if (we != '0 && td_eff >= we) begin
					n_td     = td_eff - we;
					n_active = 1'b0;
					has_res  = 1'b1;
					kind     = KIND_DONE;
					rows     = lim;
				end else begin
					n_active    = 1'b1;
					n_none      = 1'b1;
					n_rows_seen = td_eff;
					n_skip_left = off;
					if (vp_eff) begin
						if (td_eff >= off) begin
							row         = sat_add(start, td_eff - off);
							n_last_row  = row;
							n_skip_left = '0;
							n_none      = 1'b0;
							has_res     = 1'b1;
							kind        = KIND_ROW;
						end else begin
							n_skip_cnt  = W'(1);
							n_skip_left = off - td_eff - W'(1);
						end
						n_vp        = 1'b0;
						n_td        = '0;
						n_rows_seen = sat_add(td_eff, W'(1));
					end
				end
			end
			CMD_GAP: begin
				if (!active_q) begin
					has_res = 1'b1;
					kind    = KIND_IDLE_GAP;
				end else if (win_end_q != '0 && nxt >= win_end_q) begin
					n_td     = nxt - win_end_q;
					n_vp     = !op.granule_end;
					n_active = 1'b0;
					has_res  = 1'b1;
					kind     = KIND_DONE;
					rows     = limit_q;
					res.skipped_values = FIELD_W'(skip_cnt_q);
				end else if (op.granule_end) begin
					n_vp        = 1'b0;
					n_td        = grp;
					n_rows_seen = nxt;
				end else begin
					if (grp >= skip_left_q) begin
						row         = sat_add(base, grp - skip_left_q);
						n_last_row  = row;
						n_skip_left = '0;
						n_none      = 1'b0;
						has_res     = 1'b1;
						kind        = KIND_ROW;
					end else begin
						n_skip_cnt  = sat_add(skip_cnt_q, W'(1));
						n_skip_left = skip_left_q - grp - W'(1);
					end
					n_td        = '0;
					n_vp        = 1'b0;
					n_rows_seen = sat_add(nxt, W'(1));
				end
			end
			CMD_EOS: begin
				if (active_q) begin
					n_active = 1'b0;
					has_res  = 1'b1;
					kind     = KIND_DONE;
					rows     = (rows_seen_q > skip_q) ? rows_seen_q - skip_q : '0;
					res.skipped_values = FIELD_W'(skip_cnt_q);
				end
			end
			default: begin
				has_res = 1'b0;
			end
		endcase

		res.kind      = kind;
		res.row_index = FIELD_W'(row);
		res.rows_read = FIELD_W'(rows);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			td_q        <= '0;
			vp_q        <= 1'b0;
			active_q    <= 1'b0;
			rows_seen_q <= '0;
			skip_left_q <= '0;
			none_q      <= 1'b1;
			last_row_q  <= '0;
			skip_cnt_q  <= '0;
			base_q      <= '0;
			skip_q      <= '0;
			limit_q     <= '0;
			win_end_q   <= '0;
		end else if (op_pop) begin
			td_q        <= n_td;
			vp_q        <= n_vp;
			active_q    <= n_active;
			rows_seen_q <= n_rows_seen;
			skip_left_q <= n_skip_left;
			none_q      <= n_none;
			last_row_q  <= n_last_row;
			skip_cnt_q  <= n_skip_cnt;
			base_q      <= n_base;
			skip_q      <= n_skip;
			limit_q     <= n_limit;
			win_end_q   <= n_win_end;
		end
	end

endmodule

`default_nettype wire

// ----- src/sparse_gap_run_decoder.sv -----
// ----------------------------------------------------------------------------
// Sparse gap-run decoder
// Decodes gap words of a sparse column into absolute row indices.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue write port: a request is taken at a clock edge
//   with push high and full low. cmd selects begin window, gap word or end
//   of stream; begin opens a read, gap words yield row indices or a window
//   completion, end of stream reports the rows read.
//   Result side is a queue read port: the oldest result sits on result while
//   empty is low and leaves at an edge with pop high.
//   A request is registered in the front stage, then passes the middle
//   queue and the back end into the result queue. Throughput: one request
//   per cycle while the result queue is not full; a two-entry queue between
//   front and back end and a two-entry result queue keep both sides running.
//   When pop stays low the result queue fills, the back end holds, and full
//   rises once the front stage and middle queue are occupied.
//   Reset (arst_n low) empties all queues, closes any read and clears the
//   carried defaults and pending value.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_gap_run_decoder
	import sgr_pkg::*;
#(
	parameter int ROW_BITS = 62
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire in_item_t item,
	output logic          full,
	output logic          empty,
	input  wire logic     pop,
	output out_item_t     result
);

	logic      fe_valid;
	op_t       fe_op;
	logic      mid_full;
	logic      mid_empty;
	op_t       mid_op;
	logic      be_pop;
	logic      res_full;
	logic      res_push;
	out_item_t be_res;

	sgr_front #(.ROW_BITS(ROW_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.op_valid (fe_valid),
		.op       (fe_op),
		.op_full  (mid_full)
	);

	sgr_fifo #(.T(op_t), .DEPTH(2)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_valid),
		.din    (fe_op),
		.full   (mid_full),
		.pop    (be_pop),
		.dout   (mid_op),
		.empty  (mid_empty)
	);

	sgr_back #(.ROW_BITS(ROW_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (!mid_empty),
		.op       (mid_op),
		.op_pop   (be_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (be_res)
	);

	sgr_fifo #(.T(out_item_t), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (be_res),
		.full   (res_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

endmodule

`default_nettype wire

// ----- src/sgr_checker.sv -----
// ----------------------------------------------------------------------------
// Sparse gap-run decoder checker
// Port-level assertions on reset state, result holding and result field encoding.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_checker
	import sgr_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      push,
	input wire in_item_t  item,
	input wire logic      full,
	input wire logic      empty,
	input wire logic      pop,
	input wire out_item_t result
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("queues not empty under reset");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed");

	a_row_fields: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.kind == KIND_ROW |->
		result.rows_read == '0 && result.skipped_values == '0)
		else $error("row result carries count fields");

	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.kind == KIND_DONE || result.kind == KIND_IDLE_GAP) |->
		result.row_index == '0)
		else $error("completion result carries row index");

	a_idle_gap_fields: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.kind == KIND_IDLE_GAP |->
		result.rows_read == '0 && result.skipped_values == '0)
		else $error("idle gap result carries count fields");

endmodule

bind sparse_gap_run_decoder sgr_checker u_sgr_checker (.*);

`default_nettype wire
